// ===== hw/rtl/sfhcp_pkg.sv =====
package sfhcp_pkg;

  localparam int DUTY_W   = 14;
  localparam int SAMPLE_W = 10;
  localparam int Q_DEPTH  = 2;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_K    = 8'h4B;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [DUTY_W-1:0] DUTY_RESET = 14'h03FF;
  localparam logic [DUTY_W-1:0] DEC_LIMIT  = 14'd10000;

  typedef logic [2:0] rsp_kind_t;
  localparam rsp_kind_t RSP_NO = 3'd0;
  localparam rsp_kind_t RSP_OK = 3'd1;
  localparam rsp_kind_t RSP_GF = 3'd2;
  localparam rsp_kind_t RSP_GP = 3'd3;
  localparam rsp_kind_t RSP_GT = 3'd4;

  typedef struct packed {
    rsp_kind_t         kind;
    logic [7:0]        unit_char;
    logic [DUTY_W-1:0] value;
    logic [2:0]        fan;
    logic [DUTY_W-1:0] duty_one;
    logic [DUTY_W-1:0] duty_two;
  } rsp_t;

  function automatic logic [DUTY_W-1:0] dec_place(input logic [1:0] p);
    logic [DUTY_W-1:0] r;
    case (p)
      2'd0:    r = 14'd1;
      2'd1:    r = 14'd10;
      2'd2:    r = 14'd100;
      default: r = 14'd1000;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/sfhcp_if.sv =====
interface sfhcp_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;
  logic       rx_error;
  logic [9:0] sample_value;

  modport source (output valid, req_type, rx_byte, rx_error, sample_value, input ready);
  modport sink   (input valid, req_type, rx_byte, rx_error, sample_value, output ready);
endinterface

interface sfhcp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  tx_char;
  logic        last_char;
  logic [2:0]  fan_drive;
  logic [13:0] heater_one_duty;
  logic [13:0] heater_two_duty;

  modport source (output valid, tx_char, last_char, fan_drive, heater_one_duty,
                  heater_two_duty, input ready);
  modport sink   (input valid, tx_char, last_char, fan_drive, heater_one_duty,
                  heater_two_duty, output ready);
endinterface

// ===== hw/rtl/sfhcp_front.sv =====
module sfhcp_front #(
  parameter int SAMPLE_CHANNELS = 2,
  parameter int DUTY_DIGITS     = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  sfhcp_in_if.sink          in_if,
  input  logic              q_full,
  output logic              push,
  output sfhcp_pkg::rsp_t   push_rsp
);
  import sfhcp_pkg::*;

  localparam int CH_W = (SAMPLE_CHANNELS > 1) ? $clog2(SAMPLE_CHANNELS) : 1;

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_CMD      = 4'd1;
  localparam logic [3:0] PH_SET_KIND = 4'd2;
  localparam logic [3:0] PH_GET_KIND = 4'd3;
  localparam logic [3:0] PH_SF_UNIT  = 4'd4;
  localparam logic [3:0] PH_SF_STATE = 4'd5;
  localparam logic [3:0] PH_SP_UNIT  = 4'd6;
  localparam logic [3:0] PH_SP_DUTY  = 4'd7;
  localparam logic [3:0] PH_GF_UNIT  = 4'd8;
  localparam logic [3:0] PH_GP_UNIT  = 4'd9;
  localparam logic [3:0] PH_GT_UNIT  = 4'd10;

  logic [3:0]          phase_r, phase_nxt;
  logic [DUTY_W-1:0]   acc_r, acc_nxt;
  logic [3:0]          unit_r, unit_nxt;
  logic [2:0]          rem_r, rem_nxt;
  logic [2:0]          fan_r, fan_nxt;
  logic [DUTY_W-1:0]   duty_r [2];
  logic [DUTY_W-1:0]   duty_nxt [2];
  logic [SAMPLE_W-1:0] samp_r [SAMPLE_CHANNELS];
  logic [CH_W-1:0]     nch_r;

  logic              accept;
  logic [7:0]        b;
  logic              is_digit;
  logic [3:0]        d;
  logic [3:0]        d_m1;
  logic              gt_in_range;
  logic [DUTY_W-1:0] acc_step;
  logic [DUTY_W-1:0] duty_sel;
  logic [DUTY_W-1:0] samp_sel;
  rsp_kind_t         kind;
  logic [DUTY_W-1:0] value;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && in_if.ready;
  assign b           = in_if.rx_byte;
  assign is_digit    = (b >= CH_ZERO) && (b <= CH_NINE);
  assign d           = b[3:0];
  assign d_m1        = d - 4'd1;
  assign gt_in_range = (d >= 4'd1) && ({1'b0, d} <= 5'(SAMPLE_CHANNELS));
  assign acc_step    = 14'((acc_r << 3) + (acc_r << 1) + {10'd0, d});
  assign samp_sel    = gt_in_range ? 14'(samp_r[d_m1[CH_W-1:0]]) : '0;

  always_comb begin
    logic [DUTY_W-1:0] raw;
    raw = '0;
    if (d == 4'd1) raw = duty_r[0];
    else if (d == 4'd2) raw = duty_r[1];
    // four digits show the value modulo ten thousand
    duty_sel = (raw >= DEC_LIMIT) ? raw - DEC_LIMIT : raw;
  end

  always_comb begin
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    unit_nxt    = unit_r;
    rem_nxt     = rem_r;
    fan_nxt     = fan_r;
    duty_nxt[0] = duty_r[0];
    duty_nxt[1] = duty_r[1];
    push        = 1'b0;
    kind        = RSP_NO;
    value       = '0;
    if (accept && !in_if.req_type && !in_if.rx_error) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (b == CH_HASH) phase_nxt = PH_CMD;
          else push = 1'b1;
        end
        PH_CMD: begin
          if (b == CH_S) phase_nxt = PH_SET_KIND;
          else if (b == CH_G) phase_nxt = PH_GET_KIND;
          else begin
            push      = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
        PH_SET_KIND: begin
          if (b == CH_F) phase_nxt = PH_SF_UNIT;
          else if (b == CH_P) phase_nxt = PH_SP_UNIT;
          else begin
            push      = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
        PH_GET_KIND: begin
          if (b == CH_F) phase_nxt = PH_GF_UNIT;
          else if (b == CH_P) phase_nxt = PH_GP_UNIT;
          else if (b == CH_T) phase_nxt = PH_GT_UNIT;
          else begin
            push      = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
        PH_SF_UNIT, PH_SF_STATE, PH_SP_UNIT, PH_SP_DUTY,
        PH_GF_UNIT, PH_GP_UNIT, PH_GT_UNIT: begin
          // a bad digit answers NO and keeps waiting for the same digit
          if (!is_digit) push = 1'b1;
          else begin
            unique case (phase_r)
              PH_SF_UNIT: begin
                unit_nxt  = d;
                phase_nxt = PH_SF_STATE;
              end
              PH_SF_STATE: begin
                if (unit_r >= 4'd1 && unit_r <= 4'd3) begin
                  fan_nxt[2'(unit_r - 4'd1)] = (d != 4'd0);
                end
                push      = 1'b1;
                kind      = RSP_OK;
                phase_nxt = PH_IDLE;
              end
              PH_SP_UNIT: begin
                unit_nxt  = d;
                acc_nxt   = '0;
                rem_nxt   = 3'(DUTY_DIGITS);
                phase_nxt = PH_SP_DUTY;
              end
              PH_SP_DUTY: begin
                acc_nxt = acc_step;
                if (rem_r != 3'd0) rem_nxt = rem_r - 3'd1;
                if (rem_r <= 3'd1) begin
                  if (unit_r == 4'd1) duty_nxt[0] = acc_step;
                  else if (unit_r == 4'd2) duty_nxt[1] = acc_step;
                  acc_nxt   = '0;
                  push      = 1'b1;
                  kind      = RSP_OK;
                  phase_nxt = PH_IDLE;
                end
              end
              PH_GF_UNIT: begin
                push = 1'b1;
                kind = RSP_GF;
                if (d >= 4'd1 && d <= 4'd3) value = {13'd0, fan_r[2'(d_m1)]};
                phase_nxt = PH_IDLE;
              end
              PH_GP_UNIT: begin
                push      = 1'b1;
                kind      = RSP_GP;
                value     = duty_sel;
                phase_nxt = PH_IDLE;
              end
              default: begin
                push      = 1'b1;
                kind      = RSP_GT;
                value     = samp_sel;
                phase_nxt = PH_IDLE;
              end
            endcase
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    push_rsp.kind      = kind;
    push_rsp.unit_char = b;
    push_rsp.value     = value;
    push_rsp.fan       = fan_nxt;
    push_rsp.duty_one  = duty_nxt[0];
    push_rsp.duty_two  = duty_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      acc_r     <= '0;
      unit_r    <= '0;
      rem_r     <= '0;
      fan_r     <= '0;
      duty_r[0] <= DUTY_RESET;
      duty_r[1] <= DUTY_RESET;
      nch_r     <= '0;
      for (int i = 0; i < SAMPLE_CHANNELS; i++) samp_r[i] <= '0;
    end else begin
      phase_r   <= phase_nxt;
      acc_r     <= acc_nxt;
      unit_r    <= unit_nxt;
      rem_r     <= rem_nxt;
      fan_r     <= fan_nxt;
      duty_r[0] <= duty_nxt[0];
      duty_r[1] <= duty_nxt[1];
      if (accept && in_if.req_type) begin
        samp_r[nch_r] <= in_if.sample_value;
        if (nch_r == CH_W'(SAMPLE_CHANNELS - 1)) nch_r <= '0;
        else nch_r <= nch_r + 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/sfhcp_queue.sv =====
module sfhcp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sfhcp_pkg::rsp_t push_rsp,
  input  logic            pop,
  output sfhcp_pkg::rsp_t pop_rsp,
  output logic            full,
  output logic            empty
);
  import sfhcp_pkg::*;

  rsp_t       mem_r [Q_DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'(Q_DEPTH));
  assign empty   = (cnt_r == 2'd0);
  assign pop_rsp = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wr_ptr_r] <= push_rsp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push && !full) wr_ptr_r <= !wr_ptr_r;
      if (pop && !empty) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push && !full) - 2'(pop && !empty);
    end
  end

endmodule

// ===== hw/rtl/sfhcp_back.sv =====
module sfhcp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  sfhcp_pkg::rsp_t q_rsp,
  output logic            pop,
  sfhcp_out_if.source     out_if
);
  import sfhcp_pkg::*;

  logic              busy_r;
  rsp_t              job_r;
  logic [2:0]        step_r;
  logic [DUTY_W-1:0] rem_r, rem_nxt;

  logic              out_valid_r;
  logic [7:0]        char_r;
  logic              last_r;
  logic [2:0]        fan_r;
  logic [DUTY_W-1:0] d1_r, d2_r;

  logic              load;
  logic [7:0]        char_nxt;
  logic [2:0]        len;
  logic              is_last;
  logic [DUTY_W-1:0] place;
  logic [3:0]        dig;

  assign pop     = !busy_r && !q_empty;
  assign load    = busy_r && (!out_valid_r || out_if.ready);
  assign place   = dec_place(2'(3'd5 - step_r));
  assign is_last = (step_r == len - 3'd1);

  // decimal digit of the remaining value at the current place
  always_comb begin
    dig = '0;
    for (int k = 1; k < 10; k++) begin
      if (rem_r >= 14'(k) * place) dig = 4'(k);
    end
  end

  always_comb begin
    rem_nxt  = rem_r;
    char_nxt = CH_N;
    len      = 3'd2;
    unique case (job_r.kind)
      RSP_OK: char_nxt = (step_r == 3'd0) ? CH_O : CH_K;
      RSP_GF: begin
        len = 3'd3;
        if (step_r == 3'd0) char_nxt = CH_F;
        else if (step_r == 3'd1) char_nxt = job_r.unit_char;
        else char_nxt = CH_ZERO + {7'd0, job_r.value[0]};
      end
      RSP_GP, RSP_GT: begin
        len = 3'd6;
        if (step_r == 3'd0) char_nxt = (job_r.kind == RSP_GP) ? CH_P : CH_T;
        else if (step_r == 3'd1) char_nxt = job_r.unit_char;
        else begin
          char_nxt = CH_ZERO + {4'd0, dig};
          rem_nxt  = rem_r - 14'(dig) * place;
        end
      end
      default: char_nxt = (step_r == 3'd0) ? CH_N : CH_O;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= q_rsp;
      rem_r <= q_rsp.value;
    end else if (load) begin
      rem_r <= rem_nxt;
    end
    if (load) begin
      char_r <= char_nxt;
      last_r <= is_last;
      fan_r  <= job_r.fan;
      d1_r   <= job_r.duty_one;
      d2_r   <= job_r.duty_two;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (load) begin
        step_r <= step_r + 3'd1;
        if (is_last) busy_r <= 1'b0;
      end
      if (load) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.tx_char         = char_r;
  assign out_if.last_char       = last_r;
  assign out_if.fan_drive       = fan_r;
  assign out_if.heater_one_duty = d1_r;
  assign out_if.heater_two_duty = d2_r;

endmodule

// ===== hw/rtl/serial_fan_heater_command_parser_top.sv =====
// Serial fan and heater command parser. Every input request (a received byte or
// a converter sample) is taken while input ready is high; the parser state, fan
// bits, heater duties and sample slots update at the edge that takes it. A byte
// that calls for an answer leaves a response job in a two-entry queue; the output
// side registers a job when it picks it up and then sends one character per cycle
// while the output is ready (2 for OK/NO, 3 for a fan query, 6 for a duty or
// sample query, digits worked out one per character). Input ready drops only
// while the response queue is full, so the sustained rate is set by the output
// register.
module serial_fan_heater_command_parser_top #(
  parameter int SAMPLE_CHANNELS = 2,
  parameter int DUTY_DIGITS     = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  sfhcp_in_if.sink    in_if,
  sfhcp_out_if.source out_if
);
  import sfhcp_pkg::*;

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  rsp_t q_push_rsp;
  rsp_t q_pop_rsp;

  sfhcp_front #(
    .SAMPLE_CHANNELS (SAMPLE_CHANNELS),
    .DUTY_DIGITS     (DUTY_DIGITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .q_full   (q_full),
    .push     (q_push),
    .push_rsp (q_push_rsp)
  );

  sfhcp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rsp (q_push_rsp),
    .pop      (q_pop),
    .pop_rsp  (q_pop_rsp),
    .full     (q_full),
    .empty    (q_empty)
  );

  sfhcp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_rsp   (q_pop_rsp),
    .pop     (q_pop),
    .out_if  (out_if)
  );

`ifndef ASSERT_OFF
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("response pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("response popped from empty queue");

  a_push_means_ready: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (in_if.valid && in_if.ready))
    else $error("response pushed without an accepted request");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.heater_one_duty <= 14'd9999 &&
                      out_if.heater_two_duty <= 14'd9999))
    else $error("heater duty beyond four digits");
`endif

endmodule
